>>> rtl/pixel_depth_reduce_nearest_scaler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel depth reduce nearest scaler
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_DEPTH_REDUCE_NEAREST_SCALER_MACROS_SVH
`define PIXEL_DEPTH_REDUCE_NEAREST_SCALER_MACROS_SVH

// Assertion that is switched off while reset is high.
`define PDRNS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Assertion that also holds across reset.
`define PDRNS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/pdrns_pkg.sv
// ----------------------------------------------------------------------------
// pdrns_pkg
// Types, register indexes and constants of the pixel depth reduce scaler.
// ----------------------------------------------------------------------------
package pdrns_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned CW = 15;

  localparam logic [1:0] REG_DEPTH  = 2'd0;
  localparam logic [1:0] REG_SCALE  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic [11:0] pix_col;
    logic [11:0] pix_row;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } pix_in_t;

  typedef struct packed {
    logic [13:0] out_col;
    logic [13:0] out_row;
    logic [7:0]  blue_out;
    logic [7:0]  green_out;
    logic [7:0]  red_out;
    logic        last_copy;
  } pix_out_t;

  typedef struct packed {
    logic [3:0]  depth;
    logic [10:0] scale;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] x0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y0;
    logic [CW-1:0] y1;
    logic [7:0]    blue;
    logic [7:0]    green;
    logic [7:0]    red;
  } block_t;

  function automatic logic [7:0] requant_step(input logic [3:0] d);
    logic [7:0] step;
    case (d)
      4'd1:    step = 8'd255;
      4'd2:    step = 8'd85;
      4'd3:    step = 8'd36;
      4'd4:    step = 8'd17;
      4'd5:    step = 8'd8;
      4'd6:    step = 8'd4;
      4'd7:    step = 8'd2;
      default: step = 8'd1;
    endcase
    return step;
  endfunction

endpackage

>>> rtl/pdrns_map.sv
// ----------------------------------------------------------------------------
// pdrns_map
// Two register stages: coordinate products and channel levels, then the
// destination block bounds with clipping and the requantized channels.
// ----------------------------------------------------------------------------
module pdrns_map
  import pdrns_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  pix_in_t in_data,
  output logic    blk_valid,
  input  logic    blk_ready,
  output block_t  blk
);

  logic [CW-1:0] new_w;
  logic [CW-1:0] new_h;
  logic [23:0]   new_w_prod;
  logic [23:0]   new_h_prod;

  logic          a_valid;
  logic          a_in_image;
  logic [22:0]   a_c0p;
  logic [23:0]   a_c1p;
  logic [22:0]   a_r0p;
  logic [23:0]   a_r1p;
  logic [7:0]    a_lvl_b;
  logic [7:0]    a_lvl_g;
  logic [7:0]    a_lvl_r;
  logic [7:0]    a_step;

  logic          a_ready;
  logic          b_ready;
  logic [2:0]    shamt;
  logic          in_image;

  logic [CW-1:0] c0;
  logic [CW-1:0] c1;
  logic [CW-1:0] r0;
  logic [CW-1:0] r1;
  logic [CW-1:0] c1_clip;
  logic [CW-1:0] r1_clip;
  logic          nonempty;
  logic [15:0]   prod_b;
  logic [15:0]   prod_g;
  logic [15:0]   prod_r;

  assign new_w_prod = 24'(cfg.width) * 24'(cfg.scale);
  assign new_h_prod = 24'(cfg.height) * 24'(cfg.scale);

  always_ff @(posedge clk) begin
    new_w <= new_w_prod[CW+7:8];
    new_h <= new_h_prod[CW+7:8];
  end

  assign b_ready  = !blk_valid || blk_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign shamt    = 3'(4'd8 - cfg.depth);
  assign in_image = ({1'b0, in_data.pix_col} < cfg.width) &&
                    ({1'b0, in_data.pix_row} < cfg.height);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_in_image <= in_image;
      a_c0p      <= 23'(in_data.pix_col) * 23'(cfg.scale);
      a_c1p      <= 24'({1'b0, in_data.pix_col} + 13'd1) * 24'(cfg.scale);
      a_r0p      <= 23'(in_data.pix_row) * 23'(cfg.scale);
      a_r1p      <= 24'({1'b0, in_data.pix_row} + 13'd1) * 24'(cfg.scale);
      a_lvl_b    <= in_data.blue_in >> shamt;
      a_lvl_g    <= in_data.green_in >> shamt;
      a_lvl_r    <= in_data.red_in >> shamt;
      a_step     <= requant_step(cfg.depth);
    end
  end

  assign c0 = a_c0p[CW+7:8];
  assign c1 = a_c1p[CW+7:8];
  assign r0 = a_r0p[CW+7:8];
  assign r1 = a_r1p[CW+7:8];
  assign c1_clip = (c1 > new_w) ? new_w : c1;
  assign r1_clip = (r1 > new_h) ? new_h : r1;
  assign nonempty = a_in_image && (c0 < c1_clip) && (r0 < r1_clip);

  assign prod_b = 16'(a_lvl_b) * 16'(a_step);
  assign prod_g = 16'(a_lvl_g) * 16'(a_step);
  assign prod_r = 16'(a_lvl_r) * 16'(a_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (b_ready) begin
      blk_valid <= a_valid && nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      blk.x0    <= c0;
      blk.x1    <= c1_clip;
      blk.y0    <= r0;
      blk.y1    <= r1_clip;
      blk.blue  <= prod_b[7:0];
      blk.green <= prod_g[7:0];
      blk.red   <= prod_r[7:0];
    end
  end

endmodule

>>> rtl/pdrns_expand.sv
// ----------------------------------------------------------------------------
// pdrns_expand
// Walks the destination block of one pixel row by row into an output
// register, one result per cycle while the output is not stalled, marking the final one.
// ----------------------------------------------------------------------------
module pdrns_expand
  import pdrns_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     blk_valid,
  output logic     blk_ready,
  input  block_t   blk,
  output logic     out_valid,
  input  logic     out_stall,
  output pix_out_t out_data
);

  logic          hold_valid;
  block_t        hold;
  logic [CW-1:0] x;
  logic [CW-1:0] y;

  logic          out_free;
  logic          emit;
  logic [CW-1:0] x_inc;
  logic [CW-1:0] y_inc;
  logic          row_end;
  logic          at_last;
  logic          take;

  assign out_free  = !out_valid || !out_stall;
  assign emit      = hold_valid && out_free;
  assign x_inc     = x + CW'(1);
  assign y_inc     = y + CW'(1);
  assign row_end   = (x_inc == hold.x1);
  assign at_last   = row_end && (y_inc == hold.y1);
  assign blk_ready = !hold_valid || (emit && at_last);
  assign take      = blk_valid && blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (emit && at_last) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= blk;
      x    <= blk.x0;
      y    <= blk.y0;
    end else if (emit && !at_last) begin
      if (row_end) begin
        x <= hold.x0;
        y <= y_inc;
      end else begin
        x <= x_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_col   <= x[13:0];
      out_data.out_row   <= y[13:0];
      out_data.blue_out  <= hold.blue;
      out_data.green_out <= hold.green;
      out_data.red_out   <= hold.red;
      out_data.last_copy <= at_last;
    end
  end

endmodule

>>> rtl/pixel_depth_reduce_nearest_scaler.sv
// ----------------------------------------------------------------------------
// pixel_depth_reduce_nearest_scaler
// Requantizes each BGR pixel and replicates it over its nearest-neighbor
// destination block.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload     Transfer
// in        input      pix_in_t    in_valid high and in_stall low
// out       output     pix_out_t   out_valid high and out_stall low
// cfg       input      cfg_data    cfg_wen high, cfg_index selects register
//
// The first result of a pixel passes the map registers, the block register
// and the expander hold register into the output register. The expander
// emits one result per cycle unless stalled, up to 16 per pixel at 4x scale.
// Reset is synchronous and clears all valid bits and restores the registers.
// A stall on the output backs up through every stage to in_stall.
// ----------------------------------------------------------------------------
module pixel_depth_reduce_nearest_scaler
  import pdrns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pix_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pix_out_t    out_data,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [3:0]  depth_bits;
  logic [10:0] scale_q8;
  logic [12:0] src_width;
  logic [12:0] src_height;

  cfg_t   cfg;
  logic   in_ready;
  logic   blk_valid;
  logic   blk_ready;
  block_t blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_bits <= 4'd8;
      scale_q8   <= 11'd256;
      src_width  <= 13'd640;
      src_height <= 13'd480;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DEPTH:  depth_bits <= cfg_data[3:0];
        REG_SCALE:  scale_q8   <= cfg_data[10:0];
        REG_WIDTH:  src_width  <= cfg_data;
        REG_HEIGHT: src_height <= cfg_data;
        default:    depth_bits <= depth_bits;
      endcase
    end
  end

  always_comb begin
    cfg.depth  = (depth_bits == 4'd0) ? 4'd1 :
                 (depth_bits > 4'd8)  ? 4'd8 : depth_bits;
    cfg.scale  = (scale_q8 < 11'd16)   ? 11'd16 :
                 (scale_q8 > 11'd1024) ? 11'd1024 : scale_q8;
    cfg.width  = (src_width == 13'd0)        ? 13'd1 :
                 (src_width > 13'(MAX_DIM))  ? 13'(MAX_DIM) : src_width;
    cfg.height = (src_height == 13'd0)       ? 13'd1 :
                 (src_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : src_height;
  end

  assign in_stall = !in_ready;

  pdrns_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  pdrns_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/pdrns_checker.sv
// ----------------------------------------------------------------------------
// pdrns_checker
// Port-level checks of the scaler's output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_depth_reduce_nearest_scaler_macros.svh"

module pdrns_checker
  import pdrns_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_stall,
  input pix_out_t out_data
);

  `PDRNS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)
  `PDRNS_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(out_data))
  `PDRNS_ASSERT(a_burst_cont, clk, rst, out_valid && !out_stall && !out_data.last_copy |=> out_valid)
  `PDRNS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind pixel_depth_reduce_nearest_scaler pdrns_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/sv/tb_pixel_depth_reduce_nearest_scaler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_depth_reduce_nearest_scaler
// Self-checking testbench for the pixel depth reduce nearest scaler. A short
// directed table covers reset values, field extremes, clamped register values
// and block edge cases. Random phases follow under several idling mixes.
// Every output transfer is checked field by field against a local predictor.
// ----------------------------------------------------------------------------
module tb_pixel_depth_reduce_nearest_scaler;
  import pdrns_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 40;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PIX,
    ROW_NONE,
    ROW_ONE
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [12:0] val;
    pix_in_t     px;
    pix_out_t    known;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pix_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pix_out_t    out_data;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = REG_DEPTH;
  logic [12:0] cfg_data = '0;

  logic [3:0]  sh_depth = 4'd8;
  logic [10:0] sh_scale = 11'd256;
  logic [12:0] sh_width = 13'd640;
  logic [12:0] sh_height = 13'd480;

  pix_out_t    pending_pixels[$];
  int unsigned cycle = 0;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  dir_row_t dir_tab [27] = '{
    '{ROW_ONE, REG_DEPTH, 13'd0, {12'd0, 12'd0, 8'h00, 8'h80, 8'hFF},
      {14'd0, 14'd0, 8'h00, 8'h80, 8'hFF, 1'b1}},
    '{ROW_ONE, REG_DEPTH, 13'd0, {12'd639, 12'd479, 8'hFF, 8'hFF, 8'hFF},
      {14'd639, 14'd479, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
    '{ROW_NONE, REG_DEPTH, 13'd0, {12'd640, 12'd0, 8'h11, 8'h22, 8'h33}, '0},
    '{ROW_NONE, REG_DEPTH, 13'd0, {12'd0, 12'd480, 8'h11, 8'h22, 8'h33}, '0},
    '{ROW_NONE, REG_DEPTH, 13'd0, {12'd4095, 12'd4095, 8'hAA, 8'h55, 8'hAA}, '0},
    '{ROW_CFG, REG_DEPTH, 13'd1, '0, '0},
    '{ROW_ONE, REG_DEPTH, 13'd0, {12'd5, 12'd7, 8'h7F, 8'h80, 8'hFF},
      {14'd5, 14'd7, 8'h00, 8'hFF, 8'hFF, 1'b1}},
    '{ROW_CFG, REG_DEPTH, 13'd0, '0, '0},
    '{ROW_ONE, REG_DEPTH, 13'd0, {12'd6, 12'd8, 8'h80, 8'h7F, 8'h00},
      {14'd6, 14'd8, 8'hFF, 8'h00, 8'h00, 1'b1}},
    '{ROW_CFG, REG_DEPTH, 13'd15, '0, '0},
    '{ROW_ONE, REG_DEPTH, 13'd0, {12'd1, 12'd2, 8'h12, 8'h34, 8'h56},
      {14'd1, 14'd2, 8'h12, 8'h34, 8'h56, 1'b1}},
    '{ROW_CFG, REG_DEPTH, 13'd3, '0, '0},
    '{ROW_PIX, REG_DEPTH, 13'd0, {12'd3, 12'd3, 8'hFF, 8'hAB, 8'h1F}, '0},
    '{ROW_CFG, REG_SCALE, 13'd2047, '0, '0},
    '{ROW_PIX, REG_DEPTH, 13'd0, {12'd0, 12'd0, 8'hC3, 8'h3C, 8'h99}, '0},
    '{ROW_CFG, REG_SCALE, 13'd0, '0, '0},
    '{ROW_NONE, REG_DEPTH, 13'd0, {12'd0, 12'd0, 8'h01, 8'h02, 8'h03}, '0},
    '{ROW_PIX, REG_DEPTH, 13'd0, {12'd15, 12'd15, 8'hE0, 8'h70, 8'h38}, '0},
    '{ROW_CFG, REG_WIDTH, 13'd8191, '0, '0},
    '{ROW_CFG, REG_HEIGHT, 13'd8191, '0, '0},
    '{ROW_CFG, REG_SCALE, 13'd1024, '0, '0},
    '{ROW_PIX, REG_DEPTH, 13'd0, {12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF}, '0},
    '{ROW_CFG, REG_WIDTH, 13'd0, '0, '0},
    '{ROW_CFG, REG_HEIGHT, 13'd0, '0, '0},
    '{ROW_CFG, REG_SCALE, 13'd384, '0, '0},
    '{ROW_PIX, REG_DEPTH, 13'd0, {12'd0, 12'd0, 8'h5A, 8'hA5, 8'h0F}, '0},
    '{ROW_NONE, REG_DEPTH, 13'd0, {12'd1, 12'd0, 8'h5A, 8'hA5, 8'h0F}, '0}
  };

  pixel_depth_reduce_nearest_scaler uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle,
               pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                        input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] requantize(input logic [7:0] v, input int unsigned d);
    int unsigned step;
    step = 255 / ((1 << d) - 1);
    return 8'((int'(v) >> (8 - d)) * step);
  endfunction

  // Pushes every destination pixel that one source pixel covers, rows outer.
  function automatic void expand_pixel(input pix_in_t px);
    int unsigned d, s, w, h, nw, nh, c0, c1, r0, r1;
    pix_out_t o;
    d = clamp(sh_depth, 1, 8);
    s = clamp(sh_scale, 16, 1024);
    w = clamp(sh_width, 1, MAX_DIM);
    h = clamp(sh_height, 1, MAX_DIM);
    if (px.pix_col >= w || px.pix_row >= h) return;
    nw = (w * s) >> 8;
    nh = (h * s) >> 8;
    c0 = (px.pix_col * s) >> 8;
    c1 = ((px.pix_col + 1) * s) >> 8;
    r0 = (px.pix_row * s) >> 8;
    r1 = ((px.pix_row + 1) * s) >> 8;
    if (c1 > nw) c1 = nw;
    if (r1 > nh) r1 = nh;
    o.blue_out = requantize(px.blue_in, d);
    o.green_out = requantize(px.green_in, d);
    o.red_out = requantize(px.red_in, d);
    for (int unsigned y = r0; y < r1; y++) begin
      for (int unsigned x = c0; x < c1; x++) begin
        o.out_col = 14'(x);
        o.out_row = 14'(y);
        o.last_copy = (y == r1 - 1) && (x == c1 - 1);
        pending_pixels.push_back(o);
      end
    end
  endfunction

  task automatic report(input string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH at cycle %0d: %s", cycle, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : check_out
    pix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected result at column %0d row %0d", out_data.out_col,
                         out_data.out_row));
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_col", out_data.out_col, want.out_col);
        check_field("out_row", out_data.out_row, want.out_row);
        check_field("blue_out", out_data.blue_out, want.blue_out);
        check_field("green_out", out_data.green_out, want.green_out);
        check_field("red_out", out_data.red_out, want.red_out);
        check_field("last_copy", out_data.last_copy, want.last_copy);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_DEPTH:  sh_depth = val[3:0];
      REG_SCALE:  sh_scale = val[10:0];
      REG_WIDTH:  sh_width = val;
      REG_HEIGHT: sh_height = val;
      default:    ;
    endcase
    reg_writes++;
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the input off until every expected result has arrived, then lets
  // pixels that produce nothing leave the pipeline as well.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input pix_in_t px, input row_kind_e kind, input pix_out_t known);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data <= pix_in_t'({$urandom, $urandom});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    case (kind)
      ROW_ONE: pending_pixels.push_back(known);
      ROW_PIX: expand_pixel(px);
      default: ;
    endcase
  endtask

  function automatic logic [12:0] pick_size();
    if ($urandom_range(3) == 0) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(1, 48));
  endfunction

  function automatic pix_in_t pick_pixel();
    pix_in_t px;
    px.blue_in = 8'($urandom);
    px.green_in = 8'($urandom);
    px.red_in = 8'($urandom);
    if ($urandom_range(99) < 85) begin
      px.pix_col = 12'($urandom_range(0, clamp(sh_width, 1, MAX_DIM) - 1));
      px.pix_row = 12'($urandom_range(0, clamp(sh_height, 1, MAX_DIM) - 1));
    end else begin
      px.pix_col = 12'($urandom);
      px.pix_row = 12'($urandom);
    end
    return px;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_pixel(dir_tab[i].px, dir_tab[i].kind, dir_tab[i].known);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (ph == 0) begin
        write_reg(REG_DEPTH, 13'd8);
        write_reg(REG_SCALE, 13'd1024);
        write_reg(REG_WIDTH, 13'd4096);
        write_reg(REG_HEIGHT, 13'd4096);
      end else if (ph == 1) begin
        write_reg(REG_DEPTH, 13'd1);
        write_reg(REG_SCALE, 13'd16);
        write_reg(REG_WIDTH, 13'($urandom_range(16, 200)));
        write_reg(REG_HEIGHT, 13'($urandom_range(16, 200)));
      end else begin
        write_reg(REG_DEPTH, 13'($urandom_range(0, 15)));
        if ($urandom_range(9) < 2) write_reg(REG_SCALE, 13'($urandom_range(0, 2047)));
        else write_reg(REG_SCALE, 13'($urandom_range(16, 1024)));
        write_reg(REG_WIDTH, pick_size());
        write_reg(REG_HEIGHT, pick_size());
      end
      for (int k = 0; k < 16; k++) begin
        send_pixel(pick_pixel(), ROW_PIX, '0);
        if (ph == 2 && k == 8) drain();
      end
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) report("results still outstanding at the end");

    $display("Run covered %0d pixel transfers, %0d result transfers and %0d register writes,",
             pixels_sent, results_seen, reg_writes);
    $display("with clamped depth, scale and size values under four idling mixes.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
